>>> hdl/idat_pkg.sv
// Shared types for the ID allocator table: action and status codes,
// and the command and status structs between controller and datapath.
// No dependencies.
`timescale 1ns / 1ps

package idat_pkg;

  // Request actions; code 7 has no meaning and answers an invalid argument
  typedef enum logic [2:0] {
    ACT_ALLOC  = 3'd0,
    ACT_ABOVE  = 3'd1,
    ACT_CYCLIC = 3'd2,
    ACT_NEXT   = 3'd3,
    ACT_FIND   = 3'd4,
    ACT_REMOVE = 3'd5,
    ACT_CLEAR  = 3'd6
  } action_e;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_INVAL = 2'd1,
    ST_NOSPC = 2'd2
  } status_e;

  // Controller to datapath commands
  typedef struct packed {
    logic    req_load;   // capture the request transaction
    logic    plan;       // decode request, run find/remove/clear
    logic    win_load;   // load a search window into the scanner
    logic    win_wrap;   // select the wrap window instead of the primary one
    logic    scan_step;  // advance the scanner by one chunk
    logic    claim;      // take the ID that the scanner hit
    logic    res_set;    // record the result status
    status_e res_status;
    logic    emit;       // move the result into the output register
  } idat_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic bad_arg;   // request is rejected with an invalid argument
    logic is_alloc;  // request is one of the alloc actions
    logic p_empty;   // primary search window holds no ID
    logic w_empty;   // wrap search window holds no ID
    logic hit;       // current chunk holds a free ID inside the window
    logic last;      // current chunk is the last one of the window
  } idat_stat_t;

endpackage

>>> hdl/idat_datapath.sv
// Datapath of the ID allocator table: request registers, used-bit vector,
// value memory, chunked free-ID scanner and result/output registers.
// Depends on idat_pkg.
`timescale 1ns / 1ps

module idat_datapath import idat_pkg::*; #(
  parameter int ID_COUNT   = 256,
  parameter int VALUE_BITS = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [2:0]         action_i,
  input  logic signed [15:0] range_start_i,
  input  logic signed [15:0] range_end_i,
  input  logic signed [15:0] lookup_id_i,
  input  logic [31:0]        entry_value_i,
  input  idat_cmd_t          cmd_i,
  output idat_stat_t         stat_o,
  output logic [1:0]         status_o,
  output logic [7:0]         given_id_o,
  output logic [31:0]        found_value_o,
  output logic               found_o,
  output logic               table_empty_o
);

  localparam int IdBits    = $clog2(ID_COUNT);
  localparam int HB        = IdBits + 1;
  localparam int ChunkLog  = (IdBits > 5) ? 5 : IdBits - 1;
  localparam int ChunkBits = 1 << ChunkLog;
  localparam int ChIdxBits = IdBits - ChunkLog;
  localparam int SlotTotal = 1 << IdBits;
  localparam int KeepBits  = (VALUE_BITS < 32) ? VALUE_BITS : 32;
  localparam logic signed [16:0] TopS = 17'(ID_COUNT);
  localparam logic [HB-1:0]      TopH = HB'(ID_COUNT);

  // Request registers
  logic [2:0]         req_action_q;
  logic signed [15:0] req_start_q;
  logic signed [15:0] req_end_q;
  logic signed [15:0] req_look_q;
  logic [31:0]        req_value_q;

  // Table state
  logic [SlotTotal-1:0] used_q;
  logic [HB-1:0]        count_q;
  logic [HB-1:0]        hint_q;
  logic [KeepBits-1:0]  val_mem_q [ID_COUNT];
  logic [KeepBits-1:0]  rd_q;

  // Scanner state
  logic [HB-1:0]        lo_q, hi_q;
  logic [ChIdxBits-1:0] chunk_q, last_q;

  // Result and output registers
  status_e             res_status_q;
  logic [IdBits-1:0]   res_id_q;
  logic                res_found_q;
  logic                res_show_q;
  status_e             out_status_q;
  logic [7:0]          out_id_q;
  logic [31:0]         out_value_q;
  logic                out_found_q;
  logic                out_empty_q;

  // Decode signals
  logic signed [16:0] start_s, end_s, hint_s, from_s;
  logic               is_alloc, range_bad, known_act, p_ok;
  logic [HB-1:0]      lo0, hi0, p_lo, p_hi, w_lo, w_hi, win_lo, win_hi;
  logic               look_in, look_hit;
  logic [IdBits-1:0]  look_idx;

  // Scanner signals
  logic [IdBits-1:0]    row_base;
  logic [ChunkBits-1:0] row;
  logic                 hit;
  logic [IdBits-1:0]    hit_pos;

  // Capture the request transaction
  always_ff @(posedge clk_i) begin
    if (cmd_i.req_load) begin
      req_action_q <= action_i;
      req_start_q  <= range_start_i;
      req_end_q    <= range_end_i;
      req_look_q   <= lookup_id_i;
      req_value_q  <= entry_value_i;
    end
  end

  // Decode the request into search windows and a lookup
  always_comb begin
    start_s = $signed({req_start_q[15], req_start_q});
    end_s   = $signed({req_end_q[15], req_end_q});
    hint_s  = $signed(17'(hint_q));
    if (req_action_q == ACT_ABOVE && start_s < 0) begin
      start_s = '0;
    end
    if (req_action_q == ACT_ABOVE || end_s <= 0) begin
      end_s = TopS;
    end
    known_act = req_action_q inside {ACT_ALLOC, ACT_ABOVE, ACT_CYCLIC, ACT_NEXT,
                                     ACT_FIND, ACT_REMOVE, ACT_CLEAR};
    is_alloc  = req_action_q inside {ACT_ALLOC, ACT_ABOVE, ACT_CYCLIC, ACT_NEXT};
    range_bad = (req_action_q inside {ACT_ALLOC, ACT_ABOVE, ACT_CYCLIC}) &&
                (start_s < 0 || start_s >= end_s);
    lo0    = (start_s >= TopS) ? TopH : HB'(start_s);
    hi0    = (end_s >= TopS) ? TopH : HB'(end_s);
    from_s = (hint_s > start_s) ? hint_s : start_s;
    p_ok   = 1'b1;
    case (req_action_q)
      ACT_CYCLIC: begin
        p_lo = (from_s >= TopS) ? TopH : HB'(from_s);
        p_hi = hi0;
        p_ok = from_s < end_s;
        w_lo = lo0;
        w_hi = hi0;
      end
      ACT_NEXT: begin
        p_lo = hint_q;
        p_hi = TopH;
        w_lo = '0;
        w_hi = hint_q;
      end
      default: begin
        p_lo = lo0;
        p_hi = hi0;
        w_lo = '0;
        w_hi = '0;
      end
    endcase
    win_lo   = cmd_i.win_wrap ? w_lo : p_lo;
    win_hi   = cmd_i.win_wrap ? w_hi : p_hi;
    look_in  = !req_look_q[15] && ($signed({req_look_q[15], req_look_q}) < TopS);
    look_idx = req_look_q[IdBits-1:0];
    look_hit = look_in && used_q[look_idx];
  end

  // Find the lowest free ID of the current chunk inside the window
  always_comb begin
    logic [HB-1:0] pos;
    row_base = IdBits'(chunk_q) << ChunkLog;
    row      = used_q[row_base +: ChunkBits];
    hit      = 1'b0;
    hit_pos  = row_base;
    for (int b = ChunkBits - 1; b >= 0; b--) begin
      pos = {1'b0, row_base} + HB'(b);
      if (!row[b] && pos >= lo_q && pos < hi_q) begin
        hit     = 1'b1;
        hit_pos = row_base + IdBits'(b);
      end
    end
  end

  // Load a window or advance the scanner
  always_ff @(posedge clk_i) begin
    if (cmd_i.win_load) begin
      lo_q    <= win_lo;
      hi_q    <= win_hi;
      chunk_q <= ChIdxBits'(win_lo >> ChunkLog);
      last_q  <= ChIdxBits'((win_hi - HB'(1)) >> ChunkLog);
    end else if (cmd_i.scan_step) begin
      chunk_q <= chunk_q + ChIdxBits'(1);
    end
  end

  // Update used bits, count and hint
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q  <= '0;
      count_q <= '0;
      hint_q  <= '0;
    end else if (cmd_i.claim) begin
      used_q[hit_pos] <= 1'b1;
      count_q         <= count_q + HB'(1);
      hint_q          <= {1'b0, hit_pos} + HB'(1);
    end else if (cmd_i.plan) begin
      if (req_action_q == ACT_CLEAR) begin
        used_q  <= '0;
        count_q <= '0;
        hint_q  <= '0;
      end else if (req_action_q == ACT_REMOVE && look_hit) begin
        used_q[look_idx] <= 1'b0;
        count_q          <= count_q - HB'(1);
        if ({1'b0, look_idx} < hint_q) begin
          hint_q <= {1'b0, look_idx};
        end
      end
    end
  end

  // Value memory: write on claim, registered read at the lookup ID
  always_ff @(posedge clk_i) begin
    if (cmd_i.claim) begin
      val_mem_q[hit_pos] <= KeepBits'(req_value_q);
    end
    rd_q <= val_mem_q[look_idx];
  end

  // Collect the result of the current transaction
  always_ff @(posedge clk_i) begin
    if (cmd_i.res_set) begin
      res_status_q <= cmd_i.res_status;
    end
    if (cmd_i.plan) begin
      res_found_q <= look_hit && (req_action_q == ACT_FIND || req_action_q == ACT_REMOVE);
      res_show_q  <= look_hit && (req_action_q == ACT_FIND);
      res_id_q    <= '0;
    end else if (cmd_i.claim) begin
      res_id_q <= hit_pos;
    end
  end

  // Output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_status_q <= res_status_q;
      out_id_q     <= 8'(res_id_q);
      out_value_q  <= res_show_q ? 32'(rd_q) : '0;
      out_found_q  <= res_found_q;
      out_empty_q  <= (count_q == '0);
    end
  end

  assign stat_o.bad_arg  = range_bad || !known_act;
  assign stat_o.is_alloc = is_alloc;
  assign stat_o.p_empty  = !p_ok || (p_lo >= p_hi);
  assign stat_o.w_empty  = w_lo >= w_hi;
  assign stat_o.hit      = hit;
  assign stat_o.last     = chunk_q == last_q;

  assign status_o      = out_status_q;
  assign given_id_o    = out_id_q;
  assign found_value_o = out_value_q;
  assign found_o       = out_found_q;
  assign table_empty_o = out_empty_q;

`ifndef SYNTHESIS
  a_count_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(count_q) == $countones(used_q))
    else $error("used count disagrees with the used bits");

  a_hint_in_table: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hint_q <= TopH)
    else $error("hint beyond the table top");

  a_claim_free_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.claim |-> !used_q[hit_pos])
    else $error("claim of an ID already in use");
`endif

endmodule

>>> hdl/idat_ctrl.sv
// Controller of the ID allocator table: sequences decode, window scans,
// claim and result emit, and owns the channel handshakes.
// Depends on idat_pkg.
`timescale 1ns / 1ps

module idat_ctrl import idat_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  input  idat_stat_t stat_i,
  output idat_cmd_t  cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_PLAN,
    S_SCAN_P,
    S_SCAN_W,
    S_EMIT
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q;
  logic   out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  // Issue commands and pick the next state
  always_comb begin
    cmd_o            = '0;
    cmd_o.res_status = ST_OK;
    state_d          = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.req_load = 1'b1;
          state_d        = S_PLAN;
        end
      end
      S_PLAN: begin
        cmd_o.plan    = 1'b1;
        cmd_o.res_set = 1'b1;
        state_d       = S_EMIT;
        if (stat_i.bad_arg) begin
          cmd_o.res_status = ST_INVAL;
        end else if (stat_i.is_alloc) begin
          if (!stat_i.p_empty) begin
            cmd_o.win_load = 1'b1;
            state_d        = S_SCAN_P;
          end else if (!stat_i.w_empty) begin
            cmd_o.win_load = 1'b1;
            cmd_o.win_wrap = 1'b1;
            state_d        = S_SCAN_W;
          end else begin
            cmd_o.res_status = ST_NOSPC;
          end
        end
      end
      S_SCAN_P: begin
        cmd_o.scan_step = 1'b1;
        if (stat_i.hit) begin
          cmd_o.claim   = 1'b1;
          cmd_o.res_set = 1'b1;
          state_d       = S_EMIT;
        end else if (stat_i.last) begin
          if (!stat_i.w_empty) begin
            cmd_o.win_load = 1'b1;
            cmd_o.win_wrap = 1'b1;
            state_d        = S_SCAN_W;
          end else begin
            cmd_o.res_set    = 1'b1;
            cmd_o.res_status = ST_NOSPC;
            state_d          = S_EMIT;
          end
        end
      end
      S_SCAN_W: begin
        cmd_o.scan_step = 1'b1;
        if (stat_i.hit) begin
          cmd_o.claim   = 1'b1;
          cmd_o.res_set = 1'b1;
          state_d       = S_EMIT;
        end else if (stat_i.last) begin
          cmd_o.res_set    = 1'b1;
          cmd_o.res_status = ST_NOSPC;
          state_d          = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Hold state and the output valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cmd_o.emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign in_stall_o  = state_q != S_IDLE;
  assign out_valid_o = out_valid_q;

`ifndef SYNTHESIS
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("second request taken while one is in work");

  a_claim_on_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.claim |-> stat_i.hit)
    else $error("claim without a free ID");

  a_emit_has_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |-> (!out_valid_q || !out_stall_i))
    else $error("result overwrites a stalled transaction");
`endif

endmodule

>>> hdl/id_allocator_table.sv
// Top level of the ID allocator table: controller plus datapath.
// Depends on idat_pkg, idat_ctrl and idat_datapath.
//
// Usage:
//  - Request channel (in_valid_i / in_stall_o) carries action, range and
//    lookup fields and the value to store; a transaction completes when
//    valid is high and stall is low. One request is in work at a time.
//  - Result channel (out_valid_o / out_stall_i) returns one result per
//    request from an output register, so a new request is taken while an
//    earlier result still waits.
//  - Find, remove, clear and rejected requests: after the accepting edge the
//    controller passes through the plan and emit states, and the next request
//    is taken once it is back in idle.
//  - Alloc requests also scan for a free ID in chunks of up to 32 IDs: the
//    free-ID search reads one chunk of used bits per cycle, over the primary
//    window and then the wrap window, at most twice the chunks of the table.
//  - Reset clears all used bits, the count and the hint at once; stored
//    values are not cleared and are only read for IDs in use.
//  - While the receiver stalls, the result holds and a finished request
//    waits in the controller before its result is written.
`timescale 1ns / 1ps

module id_allocator_table import idat_pkg::*; #(
  parameter int ID_COUNT   = 256,
  parameter int VALUE_BITS = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [2:0]         action_i,
  input  logic signed [15:0] range_start_i,
  input  logic signed [15:0] range_end_i,
  input  logic signed [15:0] lookup_id_i,
  input  logic [31:0]        entry_value_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [1:0]         status_o,
  output logic [7:0]         given_id_o,
  output logic [31:0]        found_value_o,
  output logic               found_o,
  output logic               table_empty_o
);

  idat_cmd_t  cmd;
  idat_stat_t stat;

  // Sequencer
  idat_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // Table, scanner and result registers
  idat_datapath #(
    .ID_COUNT   (ID_COUNT),
    .VALUE_BITS (VALUE_BITS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .action_i      (action_i),
    .range_start_i (range_start_i),
    .range_end_i   (range_end_i),
    .lookup_id_i   (lookup_id_i),
    .entry_value_i (entry_value_i),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .status_o      (status_o),
    .given_id_o    (given_id_o),
    .found_value_o (found_value_o),
    .found_o       (found_o),
    .table_empty_o (table_empty_o)
  );

endmodule
